### rtl/core/pipwl_pkg.sv
// ----------------------------------------------------------------------------
// pipwl_pkg: shared constants, types and tables
// Sizes, item kind codes, the arctangent table and the ring record and CORDIC control structs.
// ----------------------------------------------------------------------------
package pipwl_pkg;

    localparam int MaxVertices = 4096;
    localparam int MaxRings    = 256;
    localparam int AngleBits   = 16;
    localparam int CordicSteps = 16;

    localparam int VaW = $clog2(MaxVertices);
    localparam int VcW = VaW + 1;
    localparam int RaW = $clog2(MaxRings);
    localparam int RcW = RaW + 1;
    // query coordinates after scaling: 26-bit signed times 20 fits in 31 bits,
    // vertex minus query fits in 34 bits
    localparam int QW  = 32;
    localparam int DW  = 34;
    localparam int CW  = DW + 2;
    localparam int SW  = AngleBits + VcW + 1;
    localparam int CsW = $clog2(CordicSteps + 1);

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [VaW-1:0] first;
        logic [VcW-1:0] total;
        logic [31:0]    min_x;
        logic [31:0]    min_y;
        logic [31:0]    max_x;
        logic [31:0]    max_y;
    } ring_rec_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } cordic_ctl_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] t;
        begin
            case (i)
                5'd0:  t = 32'h20000000;
                5'd1:  t = 32'h12E4051D;
                5'd2:  t = 32'h09FB385B;
                5'd3:  t = 32'h051111D4;
                5'd4:  t = 32'h028B0D43;
                5'd5:  t = 32'h0145D7E1;
                5'd6:  t = 32'h00A2F61E;
                5'd7:  t = 32'h00517C55;
                5'd8:  t = 32'h0028BE53;
                5'd9:  t = 32'h00145F2E;
                5'd10: t = 32'h000A2F98;
                5'd11: t = 32'h000517CC;
                5'd12: t = 32'h00028BE6;
                5'd13: t = 32'h000145F3;
                5'd14: t = 32'h0000A2F9;
                5'd15: t = 32'h0000517C;
                5'd16: t = 32'h000028BE;
                5'd17: t = 32'h0000145F;
                5'd18: t = 32'h00000A2F;
                5'd19: t = 32'h00000517;
                5'd20: t = 32'h0000028B;
                5'd21: t = 32'h00000145;
                5'd22: t = 32'h000000A2;
                5'd23: t = 32'h00000051;
                5'd24: t = 32'h00000028;
                5'd25: t = 32'h00000014;
                5'd26: t = 32'h0000000A;
                5'd27: t = 32'h00000005;
                5'd28: t = 32'h00000002;
                5'd29: t = 32'h00000001;
                default: t = 32'h00000000;
            endcase
            return t;
        end
    endfunction

endpackage

### rtl/core/pipwl_cordic.sv
// ----------------------------------------------------------------------------
// pipwl_cordic: iterative vectoring CORDIC
// One shift-add step per cycle; returns the angle in AngleBits turn units.
// ----------------------------------------------------------------------------
module pipwl_cordic
    import pipwl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] vec_x,
    input  logic signed [DW-1:0] vec_y,
    output cordic_ctl_t          ctl,
    output logic [AngleBits-1:0] angle
);

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic [31:0]          z_reg, z_next;
    logic [CsW-1:0]       step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [CW-1:0] xs, ys, sx, sy;
    logic [31:0]          t;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign t  = atan_entry(5'(step_reg));
    assign sx = CW'(vec_x);
    assign sy = CW'(vec_y);

    // load, pre-rotate, then iterate
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            step_next = '0;
            busy_next = 1'b1;
            if (sx < 0)
            begin
                x_next = -sx;
                y_next = -sy;
                z_next = 32'h80000000;
            end
            else
            begin
                x_next = sx;
                y_next = sy;
                z_next = '0;
            end
            if (vec_x == '0 && vec_y == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + t;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - t;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == CsW'(CordicSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign angle     = z_reg[31 -: AngleBits];

endmodule

### rtl/core/pipwl_store.sv
// ----------------------------------------------------------------------------
// pipwl_store: vertex and ring memories
// Synchronous memories with one registered read port each.
// ----------------------------------------------------------------------------
module pipwl_store
    import pipwl_pkg::*;
(
    input  logic             clk,
    input  logic             v_we,
    input  logic [VaW-1:0]   v_waddr,
    input  logic [63:0]      v_wdata,
    input  logic [VaW-1:0]   v_raddr,
    output logic [63:0]      v_rdata,
    input  logic             r_we,
    input  logic [RaW-1:0]   r_waddr,
    input  ring_rec_t        r_wdata,
    input  logic [RaW-1:0]   r_raddr,
    output ring_rec_t        r_rdata
);

    logic [63:0] vmem [MaxVertices];
    ring_rec_t   rmem [MaxRings];

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        v_rdata <= vmem[v_raddr];
    end

    // ring memory
    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            rmem[r_waddr] <= r_wdata;
        end
        r_rdata <= rmem[r_raddr];
    end

endmodule

### rtl/core/point_in_polygon_winding_lookup_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_winding_lookup_core: ring store and winding-angle lookup
// Loads vertex rings and answers point-in-polygon queries.
// ----------------------------------------------------------------------------
// A vertex or clear transfer is completed in the idle state, so those items can follow back
// to back. An accepted query then visits each closed ring in load order,
// reading the ring record and testing the box (RREAD, RWAIT, BOX). For a
// ring whose box holds the point it then walks each vertex: the vertex read
// (VREAD, VWAIT), the 16 steps and done flag of the single shared CORDIC
// unit, and an accumulate. A vertex that sits on the point skips the steps.
// The walk stops at the first hit, and the ST_OUT state loads the result. The
// result waits in an output register, and no new transfer is taken until it
// has been taken. Ring state lives in a ring memory updated by
// read-modify-write through a held copy of the open ring.
module point_in_polygon_winding_lookup_core
    import pipwl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic signed [23:0] delta_x,
    input  logic signed [23:0] delta_y,
    input  logic        ring_end,
    input  logic [23:0] query_x,
    input  logic [23:0] query_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [7:0]  ring_index,
    output logic        overflow
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RREAD = 9'b000000010,
        ST_RWAIT = 9'b000000100,
        ST_BOX   = 9'b000001000,
        ST_VREAD = 9'b000010000,
        ST_VWAIT = 9'b000100000,
        ST_CORD  = 9'b001000000,
        ST_ACCUM = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [23:0]        org_x_reg, org_y_reg;
    logic [RcW-1:0]     rings_reg, rings_next;
    logic [VcW-1:0]     verts_reg, verts_next;
    logic [31:0]        run_x_reg, run_x_next, run_y_reg, run_y_next;
    logic [VcW-1:0]     open_reg, open_next;
    logic               ovf_reg, ovf_next;
    ring_rec_t          cur_reg, cur_next;
    logic signed [QW-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [RcW-1:0]     ri_reg, ri_next;
    logic [VcW-1:0]     vj_reg, vj_next;
    ring_rec_t          rr_reg, rr_next;
    logic [AngleBits-1:0] prev_reg, prev_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic               found_reg, found_next;
    logic [7:0]         idx_reg, idx_next;
    logic               ovo_reg, ovo_next;

    logic               v_we, r_we;
    logic [63:0]        v_rdata;
    ring_rec_t          r_rdata;
    logic [VaW-1:0]     v_raddr;
    logic               c_start;
    cordic_ctl_t        c_ctl;
    logic [AngleBits-1:0] c_angle;
    logic signed [DW-1:0] vx, vy;
    logic [31:0]        nx, ny;
    logic signed [25:0] dqx, dqy;
    logic [AngleBits-1:0] dang;
    logic signed [SW-1:0] half_s;
    logic               accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !out_valid;
    assign nx = run_x_reg + {{8{delta_x[23]}}, delta_x};
    assign ny = run_y_reg + {{8{delta_y[23]}}, delta_y};
    assign dqx = $signed({2'b00, query_x}) - $signed({2'b00, org_x_reg});
    assign dqy = $signed({2'b00, query_y}) - $signed({2'b00, org_y_reg});
    assign vx = DW'($signed(v_rdata[63:32])) - DW'(qx_reg);
    assign vy = DW'($signed(v_rdata[31:0])) - DW'(qy_reg);
    assign dang = c_angle - prev_reg;
    assign half_s = SW'(1) <<< (AngleBits - 1);
    assign v_raddr = VaW'(rr_reg.first + vj_reg[VaW-1:0]);

    pipwl_store u_store (
        .clk     (clk),
        .v_we    (v_we),
        .v_waddr (verts_reg[VaW-1:0]),
        .v_wdata ({nx, ny}),
        .v_raddr (v_raddr),
        .v_rdata (v_rdata),
        .r_we    (r_we),
        .r_waddr (rings_reg[RaW-1:0]),
        .r_wdata (cur_next),
        .r_raddr (ri_reg[RaW-1:0]),
        .r_rdata (r_rdata)
    );

    pipwl_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .vec_x (vx),
        .vec_y (vy),
        .ctl   (c_ctl),
        .angle (c_angle)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rings_next = rings_reg;
        verts_next = verts_reg;
        run_x_next = run_x_reg;
        run_y_next = run_y_reg;
        open_next  = open_reg;
        ovf_next   = ovf_reg;
        cur_next   = cur_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        ri_next    = ri_reg;
        vj_next    = vj_reg;
        rr_next    = rr_reg;
        prev_next  = prev_reg;
        sum_next   = sum_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        ovo_next   = ovo_reg;
        v_we       = 1'b0;
        r_we       = 1'b0;
        c_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_VERTEX:
                        begin
                            if (rings_reg >= RcW'(MaxRings) || verts_reg >= VcW'(MaxVertices))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                v_we = 1'b1;
                                r_we = 1'b1;
                                run_x_next = nx;
                                run_y_next = ny;
                                if (open_reg == '0)
                                begin
                                    cur_next.first = verts_reg[VaW-1:0];
                                    cur_next.min_x = nx;
                                    cur_next.max_x = nx;
                                    cur_next.min_y = ny;
                                    cur_next.max_y = ny;
                                end
                                else
                                begin
                                    if ($signed(nx) < $signed(cur_reg.min_x)) cur_next.min_x = nx;
                                    if ($signed(ny) < $signed(cur_reg.min_y)) cur_next.min_y = ny;
                                    if ($signed(nx) > $signed(cur_reg.max_x)) cur_next.max_x = nx;
                                    if ($signed(ny) > $signed(cur_reg.max_y)) cur_next.max_y = ny;
                                end
                                open_next = open_reg + 1'b1;
                                cur_next.total = open_reg + 1'b1;
                                verts_next = verts_reg + 1'b1;
                            end
                            if (ring_end)
                            begin
                                if (open_next != '0 && rings_reg < RcW'(MaxRings))
                                begin
                                    rings_next = rings_reg + 1'b1;
                                end
                                open_next  = '0;
                                run_x_next = '0;
                                run_y_next = '0;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            rings_next = '0;
                            verts_next = '0;
                            run_x_next = '0;
                            run_y_next = '0;
                            open_next  = '0;
                            ovf_next   = 1'b0;
                        end
                        KIND_QUERY:
                        begin
                            qx_next    = QW'(dqx) * QW'(20);
                            qy_next    = QW'(dqy) * QW'(20);
                            ri_next    = '0;
                            found_next = 1'b0;
                            idx_next   = '0;
                            ovo_next   = ovf_reg;
                            state_next = ST_RREAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RREAD:
            begin
                if (ri_reg >= rings_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_RWAIT;
                end
            end
            ST_RWAIT:
            begin
                rr_next    = r_rdata;
                state_next = ST_BOX;
            end
            ST_BOX:
            begin
                if ($signed(qx_reg) <= $signed(rr_reg.min_x)
                    || $signed(qy_reg) <= $signed(rr_reg.min_y)
                    || $signed(qx_reg) >= $signed(rr_reg.max_x)
                    || $signed(qy_reg) >= $signed(rr_reg.max_y)
                    || rr_reg.total < VcW'(2))
                begin
                    ri_next    = ri_reg + 1'b1;
                    state_next = ST_RREAD;
                end
                else
                begin
                    vj_next    = '0;
                    sum_next   = '0;
                    state_next = ST_VREAD;
                end
            end
            ST_VREAD:
            begin
                state_next = ST_VWAIT;
            end
            ST_VWAIT:
            begin
                c_start    = 1'b1;
                state_next = ST_CORD;
            end
            ST_CORD:
            begin
                if (c_ctl.done)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (vj_reg != '0)
                begin
                    sum_next = sum_reg + SW'($signed(dang));
                end
                prev_next = c_angle;
                if (vj_reg + 1'b1 < rr_reg.total)
                begin
                    vj_next    = vj_reg + 1'b1;
                    state_next = ST_VREAD;
                end
                else if (sum_next >= half_s || sum_next <= -half_s)
                begin
                    found_next = 1'b1;
                    idx_next   = ri_reg[7:0];
                    state_next = ST_OUT;
                end
                else
                begin
                    ri_next    = ri_reg + 1'b1;
                    state_next = ST_RREAD;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rings_reg <= '0;
            verts_reg <= '0;
            run_x_reg <= '0;
            run_y_reg <= '0;
            open_reg  <= '0;
            ovf_reg   <= 1'b0;
            org_x_reg <= '0;
            org_y_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rings_reg <= rings_next;
            verts_reg <= verts_next;
            run_x_reg <= run_x_next;
            run_y_reg <= run_y_next;
            open_reg  <= open_next;
            ovf_reg   <= ovf_next;
            if (cfg_we && !cfg_index)
            begin
                org_x_reg <= cfg_data;
            end
            if (cfg_we && cfg_index)
            begin
                org_y_reg <= cfg_data;
            end
            // hold result until its transfer
            if (state_reg == ST_OUT)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        ri_reg    <= ri_next;
        vj_reg    <= vj_next;
        rr_reg    <= rr_next;
        prev_reg  <= prev_next;
        sum_reg   <= sum_next;
        found_reg <= found_next;
        idx_reg   <= idx_next;
        ovo_reg   <= ovo_next;
    end

    assign found      = found_reg;
    assign ring_index = idx_reg;
    assign overflow   = ovo_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_rings_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rings_reg <= RcW'(MaxRings)) else $error("ring count over limit");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    a_cordic_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        c_ctl.busy |-> state_reg == ST_CORD) else $error("cordic busy out of walk");

endmodule

### bench/point_in_polygon_winding_lookup_core_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_winding_lookup_core_test: ring store and winding lookup
// Drives vertex, query and clear transfers through valid/ready, predicts each
// query answer with an independent winding-angle model and checks every
// result field by field. Covers the ring storage limit, open rings, origin
// extremes, back-pressure and random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_in_polygon_winding_lookup_core_test;
    import pipwl_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic       REG_ORIGIN_X = 1'b0;
    localparam logic       REG_ORIGIN_Y = 1'b1;
    localparam int         Scale        = 20;

    typedef struct {
        bit       found;
        bit [7:0] ring_index;
        bit       overflow;
    } lookup_answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic signed [23:0] delta_x;
    logic signed [23:0] delta_y;
    logic        ring_end;
    logic [23:0] query_x;
    logic [23:0] query_y;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [7:0]  ring_index;
    logic        overflow;

    point_in_polygon_winding_lookup_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .ring_end   (ring_end),
        .query_x    (query_x),
        .query_y    (query_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .ring_index (ring_index),
        .overflow   (overflow)
    );

    // arctangent of 2^-i in 2^-32 turn, truncated
    localparam bit [31:0] ArcStep [0:15] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };
    localparam int CosMil [0:7] = '{1000, 707, 0, -707, -1000, -707, 0, 707};
    localparam int SinMil [0:7] = '{0, 707, 1000, 707, 0, -707, -1000, -707};

    // predicted block state
    int          pt_x [MaxVertices];
    int          pt_y [MaxVertices];
    int          poly_first [MaxRings];
    int          poly_count [MaxRings];
    int          box_lo_x [MaxRings];
    int          box_lo_y [MaxRings];
    int          box_hi_x [MaxRings];
    int          box_hi_y [MaxRings];
    int          polys_closed;
    int          pts_stored;
    bit [31:0]   walk_x;
    bit [31:0]   walk_y;
    int          open_pts;
    bit          dropped_flag;
    int unsigned org_x;
    int unsigned org_y;

    lookup_answer_t answer_q[$];

    int errors;
    int items_sent;
    int answers_checked;
    int hits_seen;
    int idle_mode;      // 0 none, 1 sender, 2 receiver, 3 both
    int hold_req;
    int hold_left;

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #400000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit [AngleBits-1:0] view_angle(longint x, longint y);
        bit [31:0] z;
        longint    xs;
        longint    ys;
        begin
            z = 32'd0;
            if (x == 0 && y == 0)
                return '0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h80000000;
            end
            for (int i = 0; i < CordicSteps; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x += ys;
                    y -= xs;
                    z += ArcStep[i];
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= ArcStep[i];
                end
            end
            return z[31 -: AngleBits];
        end
    endfunction

    function automatic bit polygon_holds(int r, longint qx, longint qy);
        int                   f;
        int                   n;
        longint               sum;
        longint               half;
        bit [AngleBits-1:0]   prev;
        bit [AngleBits-1:0]   a;
        bit [AngleBits-1:0]   d;
        begin
            f = poly_first[r];
            n = poly_count[r];
            sum = 0;
            half = longint'(1) << (AngleBits - 1);
            if (qx <= box_lo_x[r] || qy <= box_lo_y[r] ||
                qx >= box_hi_x[r] || qy >= box_hi_y[r])
                return 1'b0;
            if (n < 2)
                return 1'b0;
            prev = view_angle(pt_x[f] - qx, pt_y[f] - qy);
            for (int j = 1; j < n; j++)
            begin
                a = view_angle(pt_x[f + j] - qx, pt_y[f + j] - qy);
                d = a - prev;
                sum += longint'($signed(d));
                prev = a;
            end
            return (sum >= half) || (sum <= -half);
        end
    endfunction

    // advance the predicted state by one accepted transfer
    task automatic predict_transfer(input bit [1:0] k, input bit [23:0] dx,
                                    input bit [23:0] dy, input bit e,
                                    input bit [23:0] qx, input bit [23:0] qy);
        int             x;
        int             y;
        longint         sx;
        longint         sy;
        lookup_answer_t ans;
        begin
            if (k == KIND_VERTEX)
            begin
                if (polys_closed >= MaxRings || pts_stored >= MaxVertices)
                    dropped_flag = 1'b1;
                else
                begin
                    walk_x += {{8{dx[23]}}, dx};
                    walk_y += {{8{dy[23]}}, dy};
                    x = walk_x;
                    y = walk_y;
                    pt_x[pts_stored] = x;
                    pt_y[pts_stored] = y;
                    if (open_pts == 0)
                    begin
                        poly_first[polys_closed] = pts_stored;
                        box_lo_x[polys_closed] = x;
                        box_hi_x[polys_closed] = x;
                        box_lo_y[polys_closed] = y;
                        box_hi_y[polys_closed] = y;
                    end
                    else
                    begin
                        if (x < box_lo_x[polys_closed]) box_lo_x[polys_closed] = x;
                        if (y < box_lo_y[polys_closed]) box_lo_y[polys_closed] = y;
                        if (x > box_hi_x[polys_closed]) box_hi_x[polys_closed] = x;
                        if (y > box_hi_y[polys_closed]) box_hi_y[polys_closed] = y;
                    end
                    open_pts++;
                    poly_count[polys_closed] = open_pts;
                    pts_stored++;
                end
                if (e)
                begin
                    if (open_pts != 0 && polys_closed < MaxRings)
                        polys_closed++;
                    open_pts = 0;
                    walk_x = 0;
                    walk_y = 0;
                end
            end
            else if (k == KIND_CLEAR)
            begin
                polys_closed = 0;
                pts_stored = 0;
                walk_x = 0;
                walk_y = 0;
                open_pts = 0;
                dropped_flag = 1'b0;
            end
            else if (k == KIND_QUERY)
            begin
                sx = (longint'(qx) - longint'(org_x)) * Scale;
                sy = (longint'(qy) - longint'(org_y)) * Scale;
                ans.found = 1'b0;
                ans.ring_index = 8'd0;
                ans.overflow = dropped_flag;
                for (int r = 0; r < polys_closed; r++)
                begin
                    if (polygon_holds(r, sx, sy))
                    begin
                        ans.found = 1'b1;
                        ans.ring_index = r[7:0];
                        break;
                    end
                end
                answer_q = {answer_q, ans};
            end
        end
    endtask

    function automatic int pick_gap();
        int g;
        int pct;
        begin
            g = 0;
            pct = (idle_mode == 1) ? 85 : (idle_mode == 3) ? 14 : 0;
            while (g < 60 && $urandom_range(0, 99) < pct)
                g++;
            return g;
        end
    endfunction

    // offer one item and hold it until the transfer
    task automatic send_item(input bit [1:0] k, input int dx, input int dy, input bit e,
                             input int unsigned qx, input int unsigned qy);
        int gap;
        begin
            gap = pick_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            kind = k;
            delta_x = dx[23:0];
            delta_y = dy[23:0];
            ring_end = e;
            query_x = qx[23:0];
            query_y = qy[23:0];
            in_valid = 1'b1;
            do @(posedge clk); while (!in_ready);
            predict_transfer(k, dx[23:0], dy[23:0], e, qx[23:0], qy[23:0]);
            items_sent++;
        end
    endtask

    task automatic send_vertex(input int dx, input int dy, input bit e);
        send_item(KIND_VERTEX, dx, dy, e, $urandom, $urandom);
    endtask

    task automatic send_query(input int unsigned qx, input int unsigned qy);
        send_item(KIND_QUERY, $urandom, $urandom, 1'($urandom), qx, qy);
    endtask

    // drop valid and wait for every answer plus the block's tail latency
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_origin(input int unsigned ox, input int unsigned oy);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = REG_ORIGIN_X;
        cfg_data = ox[23:0];
        @(negedge clk);
        cfg_index = REG_ORIGIN_Y;
        cfg_data = oy[23:0];
        @(negedge clk);
        cfg_we = 1'b0;
        org_x = ox & 32'hFFFFFF;
        org_y = oy & 32'hFFFFFF;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (answer %0d, t=%0t)",
                 what, got, want, answers_checked, $realtime);
        errors++;
    endtask

    // receiver readiness, with an optional long hold
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (idle_mode == 2)
            out_ready = ($urandom_range(0, 99) >= 85);
        else if (idle_mode == 3)
            out_ready = ($urandom_range(0, 99) >= 14);
        else
            out_ready = 1'b1;
    end

    // check each result transfer against the oldest predicted answer
    always @(posedge clk)
    begin
        lookup_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("MISMATCH unexpected result at t=%0t", $realtime);
                errors++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (found !== want.found)
                    report_mismatch("found", int'(found), int'(want.found));
                if (ring_index !== want.ring_index)
                    report_mismatch("ring_index", int'(ring_index), int'(want.ring_index));
                if (overflow !== want.overflow)
                    report_mismatch("overflow", int'(overflow), int'(want.overflow));
                if (want.found)
                    hits_seen++;
                answers_checked++;
            end
        end
    end

    // square of 1/20 units from 10000 to 30000 on both axes
    task automatic send_square(input bit close);
        send_vertex(10000, 10000, 1'b0);
        send_vertex(20000, 0, 1'b0);
        send_vertex(0, 20000, 1'b0);
        send_vertex(-20000, 0, close);
    endtask

    task automatic test_directed();
        idle_mode = 0;
        write_origin(0, 0);
        send_query(1000, 1000);
        // open ring is ignored until closed
        send_square(1'b0);
        send_query(1000, 1000);
        send_vertex(0, -10000, 1'b1);
        send_query(1000, 1000);
        send_query(600, 1400);
        send_query(2000, 1000);
        send_query(500, 500);
        // extreme deltas, single-vertex ring, unused kind
        send_vertex(32'h7FFFFF, -32'h800000, 1'b0);
        send_vertex(-32'h800000, 32'h7FFFFF, 1'b1);
        send_vertex(123, 456, 1'b1);
        send_item(KIND_UNUSED, $urandom, $urandom, 1'b1, $urandom, $urandom);
        send_query(0, 0);
        send_query(32'hFFFFFF, 32'hFFFFFF);
        settle();
        write_origin(32'hFFFFFF, 32'hFFFFFF);
        send_query(0, 0);
        send_query(32'hFFFFFF, 32'hFFFFFF);
        settle();
        write_origin(0, 0);
        send_item(KIND_CLEAR, $urandom, $urandom, 1'($urandom), $urandom, $urandom);
        send_query(1000, 1000);
        settle();
    endtask

    task automatic test_ring_limit();
        idle_mode = 0;
        send_item(KIND_CLEAR, 0, 0, 1'b0, 0, 0);
        for (int i = 0; i < MaxRings - 1; i++)
            send_vertex($urandom, $urandom, 1'b1);
        send_square(1'b1);
        send_query(1000, 1000);
        // dropped vertex, then a ring end with nothing stored
        send_vertex(5, 5, 1'b0);
        send_vertex(7, 7, 1'b1);
        send_query(1000, 1000);
        send_item(KIND_CLEAR, $urandom, $urandom, 1'($urandom), $urandom, $urandom);
        send_query(1000, 1000);
        settle();
    endtask

    // receiver holds off while queries keep coming, so the block backs up
    task automatic test_backpressure();
        idle_mode = 0;
        send_square(1'b1);
        hold_req = 600;
        for (int i = 0; i < 8; i++)
            send_query($urandom_range(400, 1600), $urandom_range(400, 1600));
        settle();
        send_item(KIND_CLEAR, 0, 0, 1'b0, 0, 0);
        settle();
    endtask

    // one closed (usually) ring around a center, then probes near it
    task automatic ring_and_probes();
        int qcx;
        int qcy;
        int cx;
        int cy;
        int rad;
        int n;
        int idx;
        int px;
        int py;
        int lx;
        int ly;
        int span;
        int qx;
        int qy;
        bit cw;
        bit leave_open;
        begin
            qcx = $urandom_range(org_x > 400000 ? org_x - 400000 : 0,
                                 org_x + 400000 < 32'hFFFFFF ? org_x + 400000 : 32'hFFFFFF);
            qcy = $urandom_range(org_y > 400000 ? org_y - 400000 : 0,
                                 org_y + 400000 < 32'hFFFFFF ? org_y + 400000 : 32'hFFFFFF);
            cx = (qcx - int'(org_x)) * Scale;
            cy = (qcy - int'(org_y)) * Scale;
            rad = $urandom_range(20, 200000);
            n = $urandom_range(2, 8);
            cw = 1'($urandom);
            leave_open = ($urandom_range(0, 7) == 0);
            lx = 0;
            ly = 0;
            for (int k = 0; k < n; k++)
            begin
                idx = (k * 8) / n;
                if (cw)
                    idx = (8 - idx) % 8;
                px = cx + (rad / 1000) * CosMil[idx] + ((rad % 1000) * CosMil[idx]) / 1000;
                py = cy + (rad / 1000) * SinMil[idx] + ((rad % 1000) * SinMil[idx]) / 1000;
                send_vertex(px - lx, py - ly, (k == n - 1) && !leave_open);
                lx = px;
                ly = py;
            end
            span = rad / Scale + 2;
            repeat ($urandom_range(1, 3))
            begin
                qx = qcx + $urandom_range(0, 2 * span) - span;
                qy = qcy + $urandom_range(0, 2 * span) - span;
                if (qx < 0) qx = 0;
                if (qy < 0) qy = 0;
                if (qx > 32'hFFFFFF) qx = 32'hFFFFFF;
                if (qy > 32'hFFFFFF) qy = 32'hFFFFFF;
                send_query(qx, qy);
            end
        end
    endtask

    task automatic test_random(input int count, input int mode,
                               input int unsigned ox, input int unsigned oy);
        int start;
        int sel;
        begin
            idle_mode = 0;
            write_origin(ox, oy);
            idle_mode = mode;
            start = items_sent;
            while (items_sent - start < count)
            begin
                sel = $urandom_range(0, 99);
                if (polys_closed > 12 || sel < 4)
                    send_item(KIND_CLEAR, $urandom, $urandom, 1'($urandom),
                              $urandom, $urandom);
                else if (sel < 16)
                    send_item(2'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom),
                              $urandom, $urandom);
                else
                    ring_and_probes();
            end
            settle();
            idle_mode = 0;
        end
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        answers_checked = 0;
        hits_seen = 0;
        idle_mode = 0;
        hold_req = 0;
        hold_left = 0;
        polys_closed = 0;
        pts_stored = 0;
        walk_x = 0;
        walk_y = 0;
        open_pts = 0;
        dropped_flag = 1'b0;
        org_x = 0;
        org_y = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_VERTEX;
        delta_x = '0;
        delta_y = '0;
        ring_end = 1'b0;
        query_x = '0;
        query_y = '0;
        out_ready = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(posedge clk);

        test_directed();
        test_ring_limit();
        test_backpressure();
        test_random(218, 0, $urandom_range(400000, 16000000), $urandom_range(400000, 16000000));
        test_random(218, 1, 0, 32'hFFFFFF);
        test_random(218, 2, 32'hFFFFFF, 0);
        test_random(218, 3, $urandom, $urandom);
        settle();

        $display("Run covered %0d input transfers and %0d checked answers (%0d hits),",
                 items_sent, answers_checked, hits_seen);
        $display("including the ring storage limit, origin extremes and output back-pressure.");
        if (errors == 0 && answer_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pipwl_pkg.sv
rtl/core/pipwl_cordic.sv
rtl/core/pipwl_store.sv
rtl/core/point_in_polygon_winding_lookup_core.sv
bench/point_in_polygon_winding_lookup_core_test.sv
